### rtl/vfv_pkg.sv
package vfv_pkg;

   localparam int SIZE_X_DEF = 64;
   localparam int SIZE_Y_DEF = 64;
   localparam int SIZE_Z_DEF = 64;

   localparam int TYPE_W  = 8;
   localparam int COORD_W = 6;
   localparam int MASK_W  = 6;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 16;

   localparam int X_LSB    = 0;
   localparam int Y_LSB    = X_LSB + COORD_W;
   localparam int Z_LSB    = Y_LSB + COORD_W;
   localparam int TYPE_LSB = Z_LSB + COORD_W;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_AIR    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GLASS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAVES = 2'd2;

   localparam logic [TYPE_W-1:0] AIR_RESET    = 8'd0;
   localparam logic [TYPE_W-1:0] GLASS_RESET  = 8'd1;
   localparam logic [TYPE_W-1:0] LEAVES_RESET = 8'd2;
   localparam logic [TYPE_W-1:0] CELL_RESET   = 8'd0;

   // neighbor order, same as the face mask bits
   localparam int NB_IDX_W = 3;
   localparam logic [NB_IDX_W-1:0] NB_PZ = 3'd0;
   localparam logic [NB_IDX_W-1:0] NB_MZ = 3'd1;
   localparam logic [NB_IDX_W-1:0] NB_PY = 3'd2;
   localparam logic [NB_IDX_W-1:0] NB_MY = 3'd3;
   localparam logic [NB_IDX_W-1:0] NB_PX = 3'd4;
   localparam logic [NB_IDX_W-1:0] NB_MX = 3'd5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              is_query;
      logic              in_grid;
      logic [MASK_W-1:0] nb_ok;
   } cmd_flags_type;

   typedef struct packed {
      logic [TYPE_W-1:0] air;
      logic [TYPE_W-1:0] glass;
      logic [TYPE_W-1:0] leaves;
   } cfg_type;

endpackage

### rtl/vfv_front.sv
module vfv_front #(
   parameter int SIZE_X = vfv_pkg::SIZE_X_DEF,
   parameter int SIZE_Y = vfv_pkg::SIZE_Y_DEF,
   parameter int SIZE_Z = vfv_pkg::SIZE_Z_DEF
) (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [vfv_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   input  logic                             q_full,
   input  logic                             clear_busy,
   output logic                             push,
   output vfv_pkg::cmd_flags_type           push_flags,
   output logic [$clog2(SIZE_X*SIZE_Y*SIZE_Z)-1:0] push_addr,
   output logic [vfv_pkg::TYPE_W-1:0]       push_vtype
);

   localparam int DEPTH  = SIZE_X * SIZE_Y * SIZE_Z;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int STRIDE_Y = SIZE_X * SIZE_Z;

   logic [vfv_pkg::COORD_W-1:0] x_pos;
   logic [vfv_pkg::COORD_W-1:0] y_pos;
   logic [vfv_pkg::COORD_W-1:0] z_pos;
   logic [31:0] x_w;
   logic [31:0] y_w;
   logic [31:0] z_w;
   logic [31:0] addr_w;

   assign x_pos = req_tdata[vfv_pkg::X_LSB +: vfv_pkg::COORD_W];
   assign y_pos = req_tdata[vfv_pkg::Y_LSB +: vfv_pkg::COORD_W];
   assign z_pos = req_tdata[vfv_pkg::Z_LSB +: vfv_pkg::COORD_W];
   assign push_vtype = req_tdata[vfv_pkg::TYPE_LSB +: vfv_pkg::TYPE_W];

   assign x_w = 32'(x_pos);
   assign y_w = 32'(y_pos);
   assign z_w = 32'(z_pos);

   assign addr_w = y_w * 32'(STRIDE_Y) + z_w * 32'(SIZE_X) + x_w;
   assign push_addr = addr_w[ADDR_W-1:0];

   assign req_tready = !q_full && !clear_busy;
   assign push = req_tvalid && req_tready;

   always_comb begin
      push_flags.is_query = (req_tuser == vfv_pkg::REQ_QUERY);
      push_flags.in_grid  = (x_w < 32'(SIZE_X)) && (y_w < 32'(SIZE_Y)) && (z_w < 32'(SIZE_Z));
      push_flags.nb_ok = '0;
      push_flags.nb_ok[vfv_pkg::NB_PZ] = (z_w + 32'd1) < 32'(SIZE_Z);
      push_flags.nb_ok[vfv_pkg::NB_MZ] = (z_w != 32'd0);
      push_flags.nb_ok[vfv_pkg::NB_PY] = (y_w + 32'd1) < 32'(SIZE_Y);
      push_flags.nb_ok[vfv_pkg::NB_MY] = (y_w != 32'd0);
      push_flags.nb_ok[vfv_pkg::NB_PX] = (x_w + 32'd1) < 32'(SIZE_X);
      push_flags.nb_ok[vfv_pkg::NB_MX] = (x_w != 32'd0);
   end

endmodule

### rtl/vfv_queue.sv
module vfv_queue #(
   parameter int ADDR_W = $clog2(vfv_pkg::SIZE_X_DEF * vfv_pkg::SIZE_Y_DEF *
                                 vfv_pkg::SIZE_Z_DEF)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  vfv_pkg::cmd_flags_type      push_flags,
   input  logic [ADDR_W-1:0]           push_addr,
   input  logic [vfv_pkg::TYPE_W-1:0]  push_vtype,
   output logic                        full,
   input  logic                        pop,
   output logic                        empty,
   output vfv_pkg::cmd_flags_type      head_flags,
   output logic [ADDR_W-1:0]           head_addr,
   output logic [vfv_pkg::TYPE_W-1:0]  head_vtype
);

   localparam int QD = vfv_pkg::QUEUE_DEPTH;
   localparam int PW = vfv_pkg::QUEUE_PTR_W;
   localparam int CW = vfv_pkg::QUEUE_CNT_W;

   vfv_pkg::cmd_flags_type     flags_ff [QD];
   logic [ADDR_W-1:0]          addr_ff  [QD];
   logic [vfv_pkg::TYPE_W-1:0] vtype_ff [QD];

   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff;
   logic [PW-1:0] rd_ptr_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   assign full  = (count_ff == CW'(QD));
   assign empty = (count_ff == '0);

   assign head_flags = flags_ff[rd_ptr_ff];
   assign head_addr  = addr_ff[rd_ptr_ff];
   assign head_vtype = vtype_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QD - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QD - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         flags_ff[wr_ptr_ff] <= push_flags;
         addr_ff[wr_ptr_ff]  <= push_addr;
         vtype_ff[wr_ptr_ff] <= push_vtype;
      end
   end

endmodule

### rtl/vfv_back.sv
module vfv_back #(
   parameter int SIZE_X = vfv_pkg::SIZE_X_DEF,
   parameter int SIZE_Y = vfv_pkg::SIZE_Y_DEF,
   parameter int SIZE_Z = vfv_pkg::SIZE_Z_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  vfv_pkg::cfg_type                 cfg,
   input  logic                             q_empty,
   input  vfv_pkg::cmd_flags_type           head_flags,
   input  logic [$clog2(SIZE_X*SIZE_Y*SIZE_Z)-1:0] head_addr,
   input  logic [vfv_pkg::TYPE_W-1:0]       head_vtype,
   output logic                             q_pop,
   output logic                             clear_busy,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [vfv_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int DEPTH  = SIZE_X * SIZE_Y * SIZE_Z;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int TW     = vfv_pkg::TYPE_W;
   localparam int MW     = vfv_pkg::MASK_W;
   localparam int NW     = vfv_pkg::NB_IDX_W;

   localparam logic [ADDR_W-1:0] DX = ADDR_W'(1);
   localparam logic [ADDR_W-1:0] DZ = ADDR_W'(SIZE_X);
   localparam logic [ADDR_W-1:0] DY = ADDR_W'(SIZE_X * SIZE_Z);
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   localparam logic [2:0] STEP_FIRST = 3'd1;
   localparam logic [2:0] STEP_LAST  = 3'd7;

   logic [TW-1:0] voxel_mem [DEPTH];

   logic [1:0]        state_ff;
   logic [1:0]        state_in;
   logic [2:0]        step_ff;
   logic [2:0]        step_in;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [ADDR_W-1:0] clr_cnt_in;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] addr_in;
   logic [MW-1:0]     nb_ok_ff;
   logic [MW-1:0]     nb_ok_in;
   logic [TW-1:0]     own_ff;
   logic [TW-1:0]     own_in;
   logic [MW-2:0]     mask_ff;
   logic [MW-2:0]     mask_in;
   logic [TW-1:0]     rd_data_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [MW-1:0]     rsp_mask_ff;
   logic [MW-1:0]     rsp_mask_in;
   logic [TW-1:0]     rsp_type_ff;
   logic [TW-1:0]     rsp_type_in;

   logic              mem_we;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_addr;
   logic [TW-1:0]     mem_wdata;
   logic              out_free;
   logic              load_rsp;
   logic [NW-1:0]     rd_idx;
   logic [NW-1:0]     ev_idx;
   logic [ADDR_W-1:0] nb_addr;
   logic              nb_open;
   logic              face_now;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign clear_busy = (state_ff == ST_CLEAR);
   assign rd_idx     = step_ff - 3'd1;
   assign ev_idx     = step_ff - 3'd2;

   always_comb begin
      case (rd_idx)
         vfv_pkg::NB_PZ: nb_addr = addr_ff + DZ;
         vfv_pkg::NB_MZ: nb_addr = addr_ff - DZ;
         vfv_pkg::NB_PY: nb_addr = addr_ff + DY;
         vfv_pkg::NB_MY: nb_addr = addr_ff - DY;
         vfv_pkg::NB_PX: nb_addr = addr_ff + DX;
         vfv_pkg::NB_MX: nb_addr = addr_ff - DX;
         default:        nb_addr = addr_ff;
      endcase
   end

   // neighbor off the grid reads as air
   assign nb_open = (rd_data_ff == cfg.air) ||
                    (((rd_data_ff == cfg.glass) || (rd_data_ff == cfg.leaves)) &&
                     (rd_data_ff != own_ff));
   assign face_now = !nb_ok_ff[ev_idx] || nb_open;

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      clr_cnt_in  = clr_cnt_ff;
      addr_in     = addr_ff;
      nb_ok_in    = nb_ok_ff;
      own_in      = own_ff;
      mask_in     = mask_ff;
      rsp_mask_in = rsp_mask_ff;
      rsp_type_in = rsp_type_ff;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_addr    = addr_ff;
      mem_wdata   = head_vtype;
      q_pop       = 1'b0;
      load_rsp    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_addr   = clr_cnt_ff;
            mem_wdata  = vfv_pkg::CELL_RESET;
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               if (!head_flags.is_query) begin
                  q_pop    = 1'b1;
                  mem_we   = head_flags.in_grid;
                  mem_addr = head_addr;
               end else if (!head_flags.in_grid) begin
                  if (out_free) begin
                     q_pop       = 1'b1;
                     load_rsp    = 1'b1;
                     rsp_mask_in = '0;
                     rsp_type_in = cfg.air;
                  end
               end else begin
                  q_pop    = 1'b1;
                  mem_re   = 1'b1;
                  mem_addr = head_addr;
                  addr_in  = head_addr;
                  nb_ok_in = head_flags.nb_ok;
                  step_in  = STEP_FIRST;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (step_ff == STEP_LAST) begin
               if (out_free) begin
                  load_rsp    = 1'b1;
                  rsp_mask_in = (own_ff == cfg.air) ? '0 : {face_now, mask_ff};
                  rsp_type_in = own_ff;
                  state_in    = ST_IDLE;
               end
            end else begin
               mem_re   = nb_ok_ff[rd_idx];
               mem_addr = nb_addr;
               if (step_ff == STEP_FIRST) begin
                  own_in = rd_data_ff;
               end else begin
                  mask_in = {face_now, mask_ff[MW-2:1]};
               end
               step_in = step_ff + 3'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      nb_ok_ff <= nb_ok_in;
      own_ff   <= own_in;
      mask_ff  <= mask_in;
      if (load_rsp) begin
         rsp_mask_ff <= rsp_mask_in;
         rsp_type_ff <= rsp_type_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         voxel_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= voxel_mem[mem_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(vfv_pkg::RSP_TDATA_W - MW - TW)'(0), rsp_type_ff, rsp_mask_ff};

endmodule

### rtl/voxel_face_visibility.sv
// channel   dir  handshake               payload
// req_      in   req_tvalid/req_tready   tdata x,y,z,voxel_type; tuser req_type
// rsp_      out  rsp_tvalid/rsp_tready   tdata face_mask,center_type
// csr_      in   csr_we                  csr_addr index, csr_wdata value
//
// a write uses the voxel memory once, a query makes seven reads on its one port plus
// the final compare, a query off the grid reads nothing and waits for a free output;
// the queue is registered; an idle back end takes an item the cycle after its transfer
// after reset the memory is cleared one entry a cycle, all SIZE_X*SIZE_Y*SIZE_Z entries
// (262144 at 64x64x64), with req_tready low
// a stalled result holds in the output register; writes still drain behind it
module voxel_face_visibility #(
   parameter int SIZE_X = vfv_pkg::SIZE_X_DEF,
   parameter int SIZE_Y = vfv_pkg::SIZE_Y_DEF,
   parameter int SIZE_Z = vfv_pkg::SIZE_Z_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [vfv_pkg::REQ_TDATA_W-1:0]   req_tdata,  // x_pos, y_pos, z_pos, voxel_type
   input  logic                              req_tuser,  // req_type
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [vfv_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // face_mask, center_type
   input  logic                              csr_we,
   input  logic [vfv_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [vfv_pkg::TYPE_W-1:0]        csr_wdata
);

   localparam int ADDR_W = $clog2(SIZE_X * SIZE_Y * SIZE_Z);

   logic [vfv_pkg::TYPE_W-1:0] air_ff;
   logic [vfv_pkg::TYPE_W-1:0] glass_ff;
   logic [vfv_pkg::TYPE_W-1:0] leaves_ff;
   vfv_pkg::cfg_type cfg;

   logic                       q_full;
   logic                       q_empty;
   logic                       push;
   logic                       q_pop;
   logic                       clear_busy;
   vfv_pkg::cmd_flags_type     push_flags;
   vfv_pkg::cmd_flags_type     head_flags;
   logic [ADDR_W-1:0]          push_addr;
   logic [ADDR_W-1:0]          head_addr;
   logic [vfv_pkg::TYPE_W-1:0] push_vtype;
   logic [vfv_pkg::TYPE_W-1:0] head_vtype;

   always_ff @(posedge clock) begin
      if (reset) begin
         air_ff    <= vfv_pkg::AIR_RESET;
         glass_ff  <= vfv_pkg::GLASS_RESET;
         leaves_ff <= vfv_pkg::LEAVES_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            vfv_pkg::CSR_AIR:    air_ff    <= csr_wdata;
            vfv_pkg::CSR_GLASS:  glass_ff  <= csr_wdata;
            vfv_pkg::CSR_LEAVES: leaves_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg.air    = air_ff;
   assign cfg.glass  = glass_ff;
   assign cfg.leaves = leaves_ff;

   vfv_front #(
      .SIZE_X(SIZE_X),
      .SIZE_Y(SIZE_Y),
      .SIZE_Z(SIZE_Z)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .clear_busy (clear_busy),
      .push       (push),
      .push_flags (push_flags),
      .push_addr  (push_addr),
      .push_vtype (push_vtype)
   );

   vfv_queue #(
      .ADDR_W(ADDR_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_flags (push_flags),
      .push_addr  (push_addr),
      .push_vtype (push_vtype),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head_flags (head_flags),
      .head_addr  (head_addr),
      .head_vtype (head_vtype)
   );

   vfv_back #(
      .SIZE_X(SIZE_X),
      .SIZE_Y(SIZE_Y),
      .SIZE_Z(SIZE_Z)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_empty    (q_empty),
      .head_flags (head_flags),
      .head_addr  (head_addr),
      .head_vtype (head_vtype),
      .q_pop      (q_pop),
      .clear_busy (clear_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/vfv_checker.sv
module vfv_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [vfv_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                             csr_we,
   input logic [vfv_pkg::CSR_IDX_W-1:0]    csr_addr,
   input logic [vfv_pkg::TYPE_W-1:0]       csr_wdata
);

   localparam int MW = vfv_pkg::MASK_W;
   localparam int TW = vfv_pkg::TYPE_W;

   logic [TW-1:0] air_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         air_ff <= vfv_pkg::AIR_RESET;
      end else if (csr_we && (csr_addr == vfv_pkg::CSR_AIR)) begin
         air_ff <= csr_wdata;
      end
   end

   // memory clear starts right after reset
   assert property (@(posedge clock) reset |=> !req_tready && !rsp_tvalid)
      else $error("block not held off after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // air center has no visible faces
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[MW +: TW] == air_ff) |-> (rsp_tdata[MW-1:0] == '0))
      else $error("face mask set on air voxel");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[vfv_pkg::RSP_TDATA_W-1:MW+TW] == '0))
      else $error("result padding not zero");

endmodule

bind voxel_face_visibility vfv_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_we     (csr_we),
   .csr_addr   (csr_addr),
   .csr_wdata  (csr_wdata)
);

### test/tb_voxel_face_visibility.sv
`timescale 1ns / 100ps

module tb_voxel_face_visibility;

   localparam int TW = vfv_pkg::TYPE_W;
   localparam int CW = vfv_pkg::COORD_W;
   localparam int MW = vfv_pkg::MASK_W;
   localparam int GRID_CELLS = vfv_pkg::SIZE_X_DEF * vfv_pkg::SIZE_Y_DEF *
                               vfv_pkg::SIZE_Z_DEF;
   localparam logic [vfv_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int DRAIN_CYCLES = 40;
   // the clearing pass after reset is the longest quiet stretch
   localparam int IDLE_LIMIT = 800000;

   typedef struct {
      logic [MW-1:0] mask;
      logic [TW-1:0] center;
   } face_result_type;

   class face_scoreboard;
      bit [TW-1:0] grid [GRID_CELLS];
      bit [TW-1:0] air_t, glass_t, leaves_t;
      face_result_type visible_q [$];
      int errors, writes, queries, results, settings;

      function new();
         air_t = vfv_pkg::AIR_RESET;
         glass_t = vfv_pkg::GLASS_RESET;
         leaves_t = vfv_pkg::LEAVES_RESET;
      endfunction

      function bit in_grid(int x, int y, int z);
         return x >= 0 && x < vfv_pkg::SIZE_X_DEF && y >= 0 && y < vfv_pkg::SIZE_Y_DEF
            && z >= 0 && z < vfv_pkg::SIZE_Z_DEF;
      endfunction

      function int cell_index(int x, int y, int z);
         return (y * vfv_pkg::SIZE_Z_DEF + z) * vfv_pkg::SIZE_X_DEF + x;
      endfunction

      function bit [TW-1:0] cell_at(int x, int y, int z);
         if (!in_grid(x, y, z)) return air_t;
         return grid[cell_index(x, y, z)];
      endfunction

      function bit face_open(int x, int y, int z, bit [TW-1:0] own);
         bit [TW-1:0] nb;
         nb = cell_at(x, y, z);
         return nb == air_t || ((nb == glass_t || nb == leaves_t) && nb != own);
      endfunction

      function void set_register(logic [vfv_pkg::CSR_IDX_W-1:0] idx, bit [TW-1:0] val);
         case (idx)
            vfv_pkg::CSR_AIR:    air_t = val;
            vfv_pkg::CSR_GLASS:  glass_t = val;
            vfv_pkg::CSR_LEAVES: leaves_t = val;
            default: ;
         endcase
      endfunction

      function void note_input(logic kind, int x, int y, int z, bit [TW-1:0] vt);
         face_result_type r;
         bit [TW-1:0] own;
         if (kind == vfv_pkg::REQ_WRITE) begin
            if (in_grid(x, y, z)) grid[cell_index(x, y, z)] = vt;
            writes++;
            return;
         end
         own = cell_at(x, y, z);
         r.center = own;
         r.mask = '0;
         if (own != air_t) begin
            r.mask[vfv_pkg::NB_PZ] = face_open(x, y, z + 1, own);
            r.mask[vfv_pkg::NB_MZ] = face_open(x, y, z - 1, own);
            r.mask[vfv_pkg::NB_PY] = face_open(x, y + 1, z, own);
            r.mask[vfv_pkg::NB_MY] = face_open(x, y - 1, z, own);
            r.mask[vfv_pkg::NB_PX] = face_open(x + 1, y, z, own);
            r.mask[vfv_pkg::NB_MX] = face_open(x - 1, y, z, own);
         end
         visible_q = {visible_q, r};
         queries++;
      endfunction

      task report(string what);
         $display("error at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_result(logic [MW-1:0] mask, logic [TW-1:0] center);
         face_result_type e;
         results++;
         if (visible_q.size() == 0) begin
            report($sformatf("result with nothing pending: mask %h type %h", mask, center));
            return;
         end
         e = visible_q.pop_front();
         if (mask !== e.mask)
            report($sformatf("face_mask %h, predicted %h", mask, e.mask));
         if (center !== e.center)
            report($sformatf("center_type %h, predicted %h", center, e.center));
      endtask
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [vfv_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic req_tuser = vfv_pkg::REQ_WRITE;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [vfv_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [vfv_pkg::CSR_IDX_W-1:0] csr_addr = vfv_pkg::CSR_AIR;
   logic [TW-1:0] csr_wdata = '0;

   face_scoreboard sb = new();
   bit quiet = 1'b0;
   int idle_cycles = 0;
   int base_x, base_y, base_z;
   bit [TW-1:0] solid_a, solid_b;

   voxel_face_visibility DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 18);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[MW-1:0], rsp_tdata[MW +: TW]);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("stalled for %0d cycles with %0d results pending",
                  idle_cycles, sb.visible_q.size());
         $display("voxel_face_visibility: mismatch");
         $finish;
      end
   end

   task automatic send_item(logic kind, bit [CW-1:0] x, bit [CW-1:0] y,
                            bit [CW-1:0] z, bit [TW-1:0] vt);
      logic [vfv_pkg::REQ_TDATA_W-1:0] d;
      d = '0;
      d[vfv_pkg::X_LSB +: CW] = x;
      d[vfv_pkg::Y_LSB +: CW] = y;
      d[vfv_pkg::Z_LSB +: CW] = z;
      d[vfv_pkg::TYPE_LSB +: TW] = vt;
      while (!quiet && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tuser <= kind;
      do @(posedge clock); while (!req_tready);
      sb.note_input(kind, x, y, z, vt);
   endtask

   // drop valid, wait for every result, then let trailing writes drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.visible_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_registers(bit [TW-1:0] a, bit [TW-1:0] g, bit [TW-1:0] l);
      logic [vfv_pkg::CSR_IDX_W-1:0] idx [4];
      bit [TW-1:0] val [4];
      idx = '{vfv_pkg::CSR_AIR, vfv_pkg::CSR_GLASS, vfv_pkg::CSR_LEAVES, CSR_SPARE};
      val = '{a, g, l, TW'($urandom)};
      for (int k = 0; k < 4; k++) begin
         csr_we <= 1'b1;
         csr_addr <= idx[k];
         csr_wdata <= val[k];
         @(posedge clock);
         sb.set_register(idx[k], val[k]);
      end
      csr_we <= 1'b0;
      sb.settings++;
   endtask

   function automatic int pick_base(int hi);
      int r;
      r = $urandom_range(3);
      if (r == 0) return 0;
      if (r == 1) return hi;
      return $urandom_range(hi);
   endfunction

   function automatic bit [TW-1:0] pick_type();
      int r;
      r = $urandom_range(99);
      if (r < 30) return sb.air_t;
      if (r < 45) return sb.glass_t;
      if (r < 60) return sb.leaves_t;
      if (r < 70) return solid_a;
      if (r < 80) return solid_b;
      return TW'($urandom);
   endfunction

   // writes and queries packed into a small moving cluster so neighbors matter
   task automatic random_phase(int n);
      logic kind;
      bit [CW-1:0] x, y, z;
      solid_a = TW'($urandom);
      solid_b = TW'($urandom);
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) begin
            base_x = pick_base(vfv_pkg::SIZE_X_DEF - 3);
            base_y = pick_base(vfv_pkg::SIZE_Y_DEF - 3);
            base_z = pick_base(vfv_pkg::SIZE_Z_DEF - 3);
         end
         kind = ($urandom_range(99) < 50) ? vfv_pkg::REQ_QUERY : vfv_pkg::REQ_WRITE;
         if ($urandom_range(99) < 5) begin
            x = CW'($urandom);
            y = CW'($urandom);
            z = CW'($urandom);
         end else begin
            x = CW'(base_x + $urandom_range(2));
            y = CW'(base_y + $urandom_range(2));
            z = CW'(base_z + $urandom_range(2));
         end
         send_item(kind, x, y, z,
                   kind == vfv_pkg::REQ_QUERY ? TW'($urandom) : pick_type());
      end
      settle();
   endtask

   initial begin
      bit [TW-1:0] r;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part on the reset register values
      send_item(vfv_pkg::REQ_QUERY, 0, 0, 0, 8'hFF);       // never written
      send_item(vfv_pkg::REQ_WRITE, 0, 0, 0, 8'hFF);
      send_item(vfv_pkg::REQ_QUERY, 0, 0, 0, 8'h00);       // corner, all faces open
      send_item(vfv_pkg::REQ_WRITE, 1, 0, 0, 8'hFF);
      send_item(vfv_pkg::REQ_QUERY, 0, 0, 0, 8'h00);       // solid neighbor hides +x
      send_item(vfv_pkg::REQ_WRITE, 0, 1, 0, vfv_pkg::GLASS_RESET);
      send_item(vfv_pkg::REQ_QUERY, 0, 0, 0, 8'h00);       // glass of other type
      send_item(vfv_pkg::REQ_QUERY, 0, 1, 0, 8'h00);
      send_item(vfv_pkg::REQ_WRITE, 0, 1, 1, vfv_pkg::GLASS_RESET);
      send_item(vfv_pkg::REQ_QUERY, 0, 1, 0, 8'h00);       // glass beside glass
      send_item(vfv_pkg::REQ_WRITE, 0, 2, 0, vfv_pkg::LEAVES_RESET);
      send_item(vfv_pkg::REQ_QUERY, 0, 1, 0, 8'h00);       // glass beside leaves
      send_item(vfv_pkg::REQ_QUERY, 0, 2, 0, 8'h00);
      send_item(vfv_pkg::REQ_WRITE, 63, 63, 63, 8'h80);
      send_item(vfv_pkg::REQ_WRITE, 63, 62, 63, 8'h80);
      send_item(vfv_pkg::REQ_WRITE, 62, 63, 63, vfv_pkg::LEAVES_RESET);
      send_item(vfv_pkg::REQ_QUERY, 63, 63, 63, 8'hFF);    // far corner
      send_item(vfv_pkg::REQ_QUERY, 31, 31, 31, 8'hFF);
      send_item(vfv_pkg::REQ_WRITE, 0, 0, 0, vfv_pkg::AIR_RESET);
      send_item(vfv_pkg::REQ_QUERY, 0, 0, 0, 8'hFF);       // air voxel
      send_item(vfv_pkg::REQ_QUERY, 1, 0, 0, 8'h55);
      settle();

      // no idling on either side here
      quiet = 1'b1;
      random_phase(170);
      quiet = 1'b0;

      // air moved off zero: never-written cells turn to glass
      load_registers(8'hFF, 8'h00, 8'hFE);
      send_item(vfv_pkg::REQ_QUERY, 0, 0, 1, 8'h00);
      send_item(vfv_pkg::REQ_QUERY, 40, 40, 40, 8'h00);
      random_phase(200);

      load_registers(8'h00, 8'hFF, 8'hFF);
      random_phase(200);

      load_registers(TW'($urandom), TW'($urandom), TW'($urandom));
      random_phase(200);

      r = TW'($urandom);
      load_registers(r, r, r);
      random_phase(100);

      load_registers(vfv_pkg::AIR_RESET, vfv_pkg::GLASS_RESET, vfv_pkg::LEAVES_RESET);
      random_phase(150);

      $display("covered %0d writes and %0d queries over %0d register settings",
               sb.writes, sb.queries, sb.settings + 1);
      $display("%0d results checked, %0d errors", sb.results, sb.errors);
      if (sb.errors == 0)
         $display("voxel_face_visibility: match");
      else
         $display("voxel_face_visibility: mismatch");
      $finish;
   end

endmodule

### files.f
rtl/vfv_pkg.sv
rtl/vfv_front.sv
rtl/vfv_queue.sv
rtl/vfv_back.sv
rtl/voxel_face_visibility.sv
rtl/vfv_checker.sv
test/tb_voxel_face_visibility.sv
